// ===== rtl/cc3_pkg.sv =====
// Shared widths, payload types and status codes for the circumcircle pipeline.
`timescale 1ns / 1ps

package cc3_pkg;

   localparam int COORD_BITS    = 16;
   localparam int OUT_FRAC_BITS = 12;
   localparam int IN_FRAC_BITS  = 4;
   localparam int FRAC_SHIFT    = OUT_FRAC_BITS - IN_FRAC_BITS;
   localparam int OUT_BITS      = 32;

   localparam int DW   = COORD_BITS + 1;                       // coordinate difference
   localparam int SSW  = 2 * COORD_BITS + 1;                   // square or sum of squares
   localparam int CW   = 2 * COORD_BITS + 2;                   // difference of squared norms
   localparam int PW   = 2 * DW;                               // difference times difference
   localparam int DETW = 2 * COORD_BITS + 5;                   // determinant
   localparam int MW   = CW + DW;                              // norm term times difference
   localparam int NSW  = 3 * COORD_BITS + 5 + FRAC_SHIFT;      // scaled numerator
   localparam int QW   = NSW + 1;                              // signed quotient
   localparam int EW   = (QW + 1 > OUT_BITS + 1) ? QW + 1 : OUT_BITS + 1;
   localparam int CDW  = COORD_BITS + FRAC_SHIFT + 1;          // midpoint coordinate
   localparam int VDW  = 2 * COORD_BITS + 1 + 2 * FRAC_SHIFT;  // midpoint radicand
   localparam int VMW  = 2 * OUT_BITS + 3;                     // three-point radicand
   localparam int SQ_RAW = (VDW > VMW) ? VDW : VMW;
   localparam int SQIN = SQ_RAW + (SQ_RAW % 2);
   localparam int RTW  = SQIN / 2;

   localparam int SETUP_STAGES  = 5;
   localparam int DIV_STAGES    = NSW;
   localparam int CENTER_STAGES = 3;
   localparam int SQRT_STAGES   = RTW;

   localparam logic [OUT_BITS-1:0] SMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] SMIN = {1'b1, {(OUT_BITS-1){1'b0}}};
   localparam logic [OUT_BITS-1:0] UMAX = {OUT_BITS{1'b1}};

   localparam logic [1:0] ST_CIRCLE = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_COLL   = 2'd2;
   localparam logic [1:0] ST_SAT    = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DW-1:0]         diff_type;
   typedef logic signed [SSW-1:0]        sq_type;
   typedef logic signed [CW-1:0]         c_type;
   typedef logic signed [PW-1:0]         prod_type;
   typedef logic signed [DETW-1:0]       det_type;
   typedef logic signed [MW-1:0]         m_type;
   typedef logic signed [NSW-1:0]        num_type;
   typedef logic        [NSW-1:0]        nmag_type;
   typedef logic        [DETW-1:0]       dmag_type;
   typedef logic signed [QW-1:0]         quo_type;
   typedef logic signed [EW-1:0]         wide_type;
   typedef logic signed [CDW-1:0]        cd_type;
   typedef logic        [VDW-1:0]        vd_type;
   typedef logic        [SQIN-1:0]       sqin_type;
   typedef logic        [RTW-1:0]        root_type;

   typedef struct packed {
      coord_type first_x;
      coord_type first_y;
      coord_type second_x;
      coord_type second_y;
      coord_type third_x;
      coord_type third_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] center_x;
      logic signed [OUT_BITS-1:0] center_y;
      logic        [OUT_BITS-1:0] radius;
      logic        [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic      dup;
      logic      coll;
      coord_type x0;
      coord_type y0;
      cd_type    cxd;
      cd_type    cyd;
      vd_type    vdup;
   } div_tag_type;

   typedef struct packed {
      nmag_type    nx_mag;
      nmag_type    ny_mag;
      logic        qx_neg;
      logic        qy_neg;
      dmag_type    d_mag;
      div_tag_type tag;
   } div_in_type;

   typedef struct packed {
      quo_type     cx;
      quo_type     cy;
      div_tag_type tag;
   } div_out_type;

   typedef struct packed {
      logic                dup;
      logic                coll;
      logic                big;
      logic                satc;
      logic [OUT_BITS-1:0] cx32;
      logic [OUT_BITS-1:0] cy32;
   } sq_tag_type;

   typedef struct packed {
      sqin_type   v;
      sq_tag_type tag;
   } sq_in_type;

   typedef struct packed {
      root_type   root;
      sq_tag_type tag;
   } sq_out_type;

endpackage

// ===== rtl/cc3_setup.sv =====
// Front stages: differences, duplicate detection, products, determinant and numerators.
`timescale 1ns / 1ps

module cc3_setup (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  cc3_pkg::req_type    in_data,
   output logic                out_vld,
   output cc3_pkg::div_in_type out_data
);

   typedef struct packed {
      cc3_pkg::diff_type  d02x, d02y, d12x, d12y;
      cc3_pkg::coord_type x0, y0, x1, y1, x2, y2;
      logic               dup;
      cc3_pkg::diff_type  ddx, ddy, sx, sy;
   } s1_type;

   typedef struct packed {
      cc3_pkg::diff_type  d02x, d02y, d12x, d12y;
      cc3_pkg::coord_type x0, y0;
      cc3_pkg::prod_type  p1, p2;
      cc3_pkg::sq_type    q0x, q0y, q1x, q1y, q2x, q2y;
      logic               dup;
      cc3_pkg::prod_type  ddx2, ddy2;
      cc3_pkg::cd_type    cxd, cyd;
   } s2_type;

   typedef struct packed {
      cc3_pkg::diff_type  d02x, d02y, d12x, d12y;
      cc3_pkg::coord_type x0, y0;
      cc3_pkg::det_type   det;
      cc3_pkg::c_type     c02, c12;
      logic               dup;
      cc3_pkg::vd_type    vdup;
      cc3_pkg::cd_type    cxd, cyd;
   } s3_type;

   typedef struct packed {
      cc3_pkg::m_type     m1, m2, m3, m4;
      cc3_pkg::det_type   det;
      cc3_pkg::coord_type x0, y0;
      logic               dup;
      cc3_pkg::vd_type    vdup;
      cc3_pkg::cd_type    cxd, cyd;
   } s4_type;

   logic [cc3_pkg::SETUP_STAGES-1:0] vld_ff, vld_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   cc3_pkg::div_in_type s5_ff, s5_in;

   // stage 1: differences and duplicate check
   always_comb begin
      logic e01, e02, e12;
      cc3_pkg::coord_type xb, yb;
      e01 = (in_data.first_x == in_data.second_x) && (in_data.first_y == in_data.second_y);
      e02 = (in_data.first_x == in_data.third_x) && (in_data.first_y == in_data.third_y);
      e12 = (in_data.second_x == in_data.third_x) && (in_data.second_y == in_data.third_y);
      xb  = e01 ? in_data.third_x : in_data.second_x;
      yb  = e01 ? in_data.third_y : in_data.second_y;
      s1_in.x0   = in_data.first_x;
      s1_in.y0   = in_data.first_y;
      s1_in.x1   = in_data.second_x;
      s1_in.y1   = in_data.second_y;
      s1_in.x2   = in_data.third_x;
      s1_in.y2   = in_data.third_y;
      s1_in.d02x = cc3_pkg::diff_type'(in_data.first_x) - cc3_pkg::diff_type'(in_data.third_x);
      s1_in.d02y = cc3_pkg::diff_type'(in_data.first_y) - cc3_pkg::diff_type'(in_data.third_y);
      s1_in.d12x = cc3_pkg::diff_type'(in_data.second_x) - cc3_pkg::diff_type'(in_data.third_x);
      s1_in.d12y = cc3_pkg::diff_type'(in_data.second_y) - cc3_pkg::diff_type'(in_data.third_y);
      s1_in.dup  = e01 | e02 | e12;
      s1_in.ddx  = cc3_pkg::diff_type'(in_data.first_x) - cc3_pkg::diff_type'(xb);
      s1_in.ddy  = cc3_pkg::diff_type'(in_data.first_y) - cc3_pkg::diff_type'(yb);
      s1_in.sx   = cc3_pkg::diff_type'(in_data.first_x) + cc3_pkg::diff_type'(xb);
      s1_in.sy   = cc3_pkg::diff_type'(in_data.first_y) + cc3_pkg::diff_type'(yb);
   end

   // stage 2: products, squares, midpoint with round half away from zero
   always_comb begin
      cc3_pkg::cd_type tx, ty;
      logic [cc3_pkg::CDW-1:0] mx, my, hx, hy;
      tx = cc3_pkg::cd_type'(s1_ff.sx) <<< cc3_pkg::FRAC_SHIFT;
      ty = cc3_pkg::cd_type'(s1_ff.sy) <<< cc3_pkg::FRAC_SHIFT;
      mx = tx[cc3_pkg::CDW-1] ? -tx : tx;
      my = ty[cc3_pkg::CDW-1] ? -ty : ty;
      hx = (mx + 1'b1) >> 1;
      hy = (my + 1'b1) >> 1;
      s2_in.cxd  = tx[cc3_pkg::CDW-1] ? -cc3_pkg::cd_type'(hx) : cc3_pkg::cd_type'(hx);
      s2_in.cyd  = ty[cc3_pkg::CDW-1] ? -cc3_pkg::cd_type'(hy) : cc3_pkg::cd_type'(hy);
      s2_in.d02x = s1_ff.d02x;
      s2_in.d02y = s1_ff.d02y;
      s2_in.d12x = s1_ff.d12x;
      s2_in.d12y = s1_ff.d12y;
      s2_in.x0   = s1_ff.x0;
      s2_in.y0   = s1_ff.y0;
      s2_in.p1   = s1_ff.d02x * s1_ff.d12y;
      s2_in.p2   = s1_ff.d12x * s1_ff.d02y;
      s2_in.q0x  = s1_ff.x0 * s1_ff.x0;
      s2_in.q0y  = s1_ff.y0 * s1_ff.y0;
      s2_in.q1x  = s1_ff.x1 * s1_ff.x1;
      s2_in.q1y  = s1_ff.y1 * s1_ff.y1;
      s2_in.q2x  = s1_ff.x2 * s1_ff.x2;
      s2_in.q2y  = s1_ff.y2 * s1_ff.y2;
      s2_in.dup  = s1_ff.dup;
      s2_in.ddx2 = s1_ff.ddx * s1_ff.ddx;
      s2_in.ddy2 = s1_ff.ddy * s1_ff.ddy;
   end

   // stage 3: determinant, norm differences, midpoint radicand
   always_comb begin
      cc3_pkg::sq_type n0, n1, n2;
      n0 = s2_ff.q0x + s2_ff.q0y;
      n1 = s2_ff.q1x + s2_ff.q1y;
      n2 = s2_ff.q2x + s2_ff.q2y;
      s3_in.d02x = s2_ff.d02x;
      s3_in.d02y = s2_ff.d02y;
      s3_in.d12x = s2_ff.d12x;
      s3_in.d12y = s2_ff.d12y;
      s3_in.x0   = s2_ff.x0;
      s3_in.y0   = s2_ff.y0;
      s3_in.det  = (cc3_pkg::det_type'(s2_ff.p1) - cc3_pkg::det_type'(s2_ff.p2)) <<< 2;
      s3_in.c02  = cc3_pkg::c_type'(n0) - cc3_pkg::c_type'(n2);
      s3_in.c12  = cc3_pkg::c_type'(n1) - cc3_pkg::c_type'(n2);
      s3_in.dup  = s2_ff.dup;
      s3_in.vdup = (cc3_pkg::vd_type'(s2_ff.ddx2) + cc3_pkg::vd_type'(s2_ff.ddy2))
                   << (2 * cc3_pkg::FRAC_SHIFT);
      s3_in.cxd  = s2_ff.cxd;
      s3_in.cyd  = s2_ff.cyd;
   end

   // stage 4: numerator products
   always_comb begin
      s4_in.m1   = s3_ff.c02 * s3_ff.d12y;
      s4_in.m2   = s3_ff.c12 * s3_ff.d02y;
      s4_in.m3   = s3_ff.d02x * s3_ff.c12;
      s4_in.m4   = s3_ff.d12x * s3_ff.c02;
      s4_in.det  = s3_ff.det;
      s4_in.x0   = s3_ff.x0;
      s4_in.y0   = s3_ff.y0;
      s4_in.dup  = s3_ff.dup;
      s4_in.vdup = s3_ff.vdup;
      s4_in.cxd  = s3_ff.cxd;
      s4_in.cyd  = s3_ff.cyd;
   end

   // stage 5: scaled numerators, split into sign and magnitude
   always_comb begin
      cc3_pkg::num_type nx, ny;
      nx = (cc3_pkg::num_type'(s4_ff.m1) - cc3_pkg::num_type'(s4_ff.m2))
           <<< (cc3_pkg::FRAC_SHIFT + 1);
      ny = (cc3_pkg::num_type'(s4_ff.m3) - cc3_pkg::num_type'(s4_ff.m4))
           <<< (cc3_pkg::FRAC_SHIFT + 1);
      s5_in.nx_mag   = nx[cc3_pkg::NSW-1] ? -nx : nx;
      s5_in.ny_mag   = ny[cc3_pkg::NSW-1] ? -ny : ny;
      s5_in.qx_neg   = nx[cc3_pkg::NSW-1] ^ s4_ff.det[cc3_pkg::DETW-1];
      s5_in.qy_neg   = ny[cc3_pkg::NSW-1] ^ s4_ff.det[cc3_pkg::DETW-1];
      s5_in.d_mag    = s4_ff.det[cc3_pkg::DETW-1] ? -s4_ff.det : s4_ff.det;
      s5_in.tag.dup  = s4_ff.dup;
      s5_in.tag.coll = (s4_ff.det == '0);
      s5_in.tag.x0   = s4_ff.x0;
      s5_in.tag.y0   = s4_ff.y0;
      s5_in.tag.cxd  = s4_ff.cxd;
      s5_in.tag.cyd  = s4_ff.cyd;
      s5_in.tag.vdup = s4_ff.vdup;
   end

   assign vld_in = {vld_ff[cc3_pkg::SETUP_STAGES-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_vld  = vld_ff[cc3_pkg::SETUP_STAGES-1];
   assign out_data = s5_ff;

endmodule

// ===== rtl/cc3_divide.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, rounded to nearest.
`timescale 1ns / 1ps

module cc3_divide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  cc3_pkg::div_in_type  in_data,
   output logic                 out_vld,
   output cc3_pkg::div_out_type out_data
);

   typedef struct packed {
      cc3_pkg::dmag_type rem;
      cc3_pkg::nmag_type nq;
   } lane_type;

   typedef struct packed {
      lane_type             lx;
      lane_type             ly;
      cc3_pkg::dmag_type    d_mag;
      logic                 qx_neg;
      logic                 qy_neg;
      cc3_pkg::div_tag_type tag;
   } div_stage_type;

   localparam int N = cc3_pkg::DIV_STAGES;

   function automatic lane_type lane_step(lane_type cur, cc3_pkg::dmag_type d);
      logic [cc3_pkg::DETW:0] rsh, dif;
      logic                   ge;
      lane_type               nxt;
      rsh = {cur.rem, cur.nq[cc3_pkg::NSW-1]};
      dif = rsh - {1'b0, d};
      ge  = (rsh >= {1'b0, d});
      nxt.rem = ge ? dif[cc3_pkg::DETW-1:0] : rsh[cc3_pkg::DETW-1:0];
      nxt.nq  = {cur.nq[cc3_pkg::NSW-2:0], ge};
      return nxt;
   endfunction

   function automatic div_stage_type div_step(div_stage_type cur);
      div_stage_type nxt;
      nxt    = cur;
      nxt.lx = lane_step(cur.lx, cur.d_mag);
      nxt.ly = lane_step(cur.ly, cur.d_mag);
      return nxt;
   endfunction

   function automatic cc3_pkg::quo_type round_q(lane_type l, cc3_pkg::dmag_type d, logic neg);
      logic              up;
      cc3_pkg::quo_type  qm;
      up = ({l.rem, 1'b0} >= {1'b0, d});
      qm = cc3_pkg::quo_type'({1'b0, l.nq}) + cc3_pkg::quo_type'(up);
      return neg ? -qm : qm;
   endfunction

   div_stage_type        head;
   div_stage_type        st_ff [N];
   div_stage_type        st_in [N];
   logic [N:0]           vld_ff, vld_in;
   cc3_pkg::div_out_type rnd_ff, rnd_in;

   always_comb begin
      head.lx.rem = '0;
      head.lx.nq  = in_data.nx_mag;
      head.ly.rem = '0;
      head.ly.nq  = in_data.ny_mag;
      head.d_mag  = in_data.d_mag;
      head.qx_neg = in_data.qx_neg;
      head.qy_neg = in_data.qy_neg;
      head.tag    = in_data.tag;
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < N; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign st_in[k] = div_step(head);
      end else begin : g_rest
         assign st_in[k] = div_step(st_ff[k-1]);
      end
   end

   always_comb begin
      rnd_in.cx  = round_q(st_ff[N-1].lx, st_ff[N-1].d_mag, st_ff[N-1].qx_neg);
      rnd_in.cy  = round_q(st_ff[N-1].ly, st_ff[N-1].d_mag, st_ff[N-1].qy_neg);
      rnd_in.tag = st_ff[N-1].tag;
   end

   assign vld_in = {vld_ff[N-1:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            st_ff[k] <= st_in[k];
         end
         rnd_ff <= rnd_in;
      end
   end

   assign out_vld  = vld_ff[N];
   assign out_data = rnd_ff;

endmodule

// ===== rtl/cc3_center.sv =====
// Center selection and clamping, distance to the first point, radicand for the root.
`timescale 1ns / 1ps

module cc3_center (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  cc3_pkg::div_out_type in_data,
   output logic                 out_vld,
   output cc3_pkg::sq_in_type   out_data
);

   typedef struct packed {
      cc3_pkg::sq_tag_type         tag;
      logic [cc3_pkg::OUT_BITS-1:0] dx, dy;
      cc3_pkg::vd_type             vdup;
   } m1_type;

   typedef struct packed {
      cc3_pkg::sq_tag_type            tag;
      logic [2*cc3_pkg::OUT_BITS-1:0] dx2, dy2;
      cc3_pkg::vd_type                vdup;
   } m2_type;

   function automatic logic fits_s32(cc3_pkg::wide_type v);
      logic [cc3_pkg::EW-cc3_pkg::OUT_BITS:0] top;
      top = v[cc3_pkg::EW-1:cc3_pkg::OUT_BITS-1];
      return (&top) | ~(|top);
   endfunction

   function automatic logic [cc3_pkg::OUT_BITS-1:0] clamp_s32(cc3_pkg::wide_type v);
      logic [cc3_pkg::OUT_BITS-1:0] r;
      if (fits_s32(v)) begin
         r = v[cc3_pkg::OUT_BITS-1:0];
      end else begin
         r = v[cc3_pkg::EW-1] ? cc3_pkg::SMIN : cc3_pkg::SMAX;
      end
      return r;
   endfunction

   logic [cc3_pkg::CENTER_STAGES-1:0] vld_ff, vld_in;
   m1_type             m1_ff, m1_in;
   m2_type             m2_ff, m2_in;
   cc3_pkg::sq_in_type m3_ff, m3_in;

   // stage 1: pick center, offset from the first point, clamp
   always_comb begin
      cc3_pkg::wide_type cx, cy, ex, ey;
      logic [cc3_pkg::EW-1:0] ax, ay;
      cx = in_data.tag.dup ? cc3_pkg::wide_type'(in_data.tag.cxd)
                           : cc3_pkg::wide_type'(in_data.cx);
      cy = in_data.tag.dup ? cc3_pkg::wide_type'(in_data.tag.cyd)
                           : cc3_pkg::wide_type'(in_data.cy);
      ex = cx - (cc3_pkg::wide_type'(in_data.tag.x0) <<< cc3_pkg::FRAC_SHIFT);
      ey = cy - (cc3_pkg::wide_type'(in_data.tag.y0) <<< cc3_pkg::FRAC_SHIFT);
      ax = ex[cc3_pkg::EW-1] ? -ex : ex;
      ay = ey[cc3_pkg::EW-1] ? -ey : ey;
      m1_in.tag.dup  = in_data.tag.dup;
      m1_in.tag.coll = in_data.tag.coll;
      m1_in.tag.big  = ~in_data.tag.dup &
                       ((|ax[cc3_pkg::EW-1:cc3_pkg::OUT_BITS]) |
                        (|ay[cc3_pkg::EW-1:cc3_pkg::OUT_BITS]));
      m1_in.tag.satc = ~(fits_s32(cx) & fits_s32(cy));
      m1_in.tag.cx32 = clamp_s32(cx);
      m1_in.tag.cy32 = clamp_s32(cy);
      m1_in.dx       = ax[cc3_pkg::OUT_BITS-1:0];
      m1_in.dy       = ay[cc3_pkg::OUT_BITS-1:0];
      m1_in.vdup     = in_data.tag.vdup;
   end

   // stage 2: squares
   always_comb begin
      m2_in.tag  = m1_ff.tag;
      m2_in.dx2  = m1_ff.dx * m1_ff.dx;
      m2_in.dy2  = m1_ff.dy * m1_ff.dy;
      m2_in.vdup = m1_ff.vdup;
   end

   // stage 3: radicand for four times the squared radius
   always_comb begin
      logic [2*cc3_pkg::OUT_BITS:0] sum;
      sum = {1'b0, m2_ff.dx2} + {1'b0, m2_ff.dy2};
      m3_in.v   = m2_ff.tag.dup ? cc3_pkg::sqin_type'(m2_ff.vdup)
                                : (cc3_pkg::sqin_type'(sum) << 2);
      m3_in.tag = m2_ff.tag;
   end

   assign vld_in = {vld_ff[cc3_pkg::CENTER_STAGES-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
      end
   end

   assign out_vld  = vld_ff[cc3_pkg::CENTER_STAGES-1];
   assign out_data = m3_ff;

endmodule

// ===== rtl/cc3_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module cc3_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  cc3_pkg::sq_in_type  in_data,
   output logic                out_vld,
   output cc3_pkg::sq_out_type out_data
);

   localparam int N = cc3_pkg::SQRT_STAGES;

   typedef struct packed {
      logic [cc3_pkg::RTW+1:0] rem;
      cc3_pkg::root_type       root;
      cc3_pkg::sqin_type       a;
      cc3_pkg::sq_tag_type     tag;
   } sq_stage_type;

   function automatic sq_stage_type sq_step(sq_stage_type cur);
      logic [cc3_pkg::RTW+3:0] rsh, t, dif;
      logic                    ge;
      sq_stage_type            nxt;
      rsh = {cur.rem, cur.a[cc3_pkg::SQIN-1 -: 2]};
      t   = {2'b00, cur.root, 2'b01};
      dif = rsh - t;
      ge  = (rsh >= t);
      nxt      = cur;
      nxt.rem  = ge ? dif[cc3_pkg::RTW+1:0] : rsh[cc3_pkg::RTW+1:0];
      nxt.root = {cur.root[cc3_pkg::RTW-2:0], ge};
      nxt.a    = cur.a << 2;
      return nxt;
   endfunction

   sq_stage_type head;
   sq_stage_type st_ff [N];
   sq_stage_type st_in [N];
   logic [N-1:0] vld_ff, vld_in;

   always_comb begin
      head.rem  = '0;
      head.root = '0;
      head.a    = in_data.v;
      head.tag  = in_data.tag;
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign st_in[k] = sq_step(head);
      end else begin : g_rest
         assign st_in[k] = sq_step(st_ff[k-1]);
      end
   end

   assign vld_in = {vld_ff[N-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_vld       = vld_ff[N-1];
   assign out_data.root = st_ff[N-1].root;
   assign out_data.tag  = st_ff[N-1].tag;

endmodule

// ===== rtl/circumcircle_three_points.sv =====
// Top level: circumcircle pipeline, result rounding and status, output register with skid.
//
//   channel  direction  handshake                payload
//   req_     in         req_valid / req_ready    cc3_pkg::req_type (three points, Q12.4)
//   rsp_     out        rsp_valid / rsp_ready    cc3_pkg::rsp_type (center, radius, status)
//
// One point triple per cycle while req_ready is high; the bit-per-stage divider (one stage
// per numerator bit) and root dominate the depth of the pipeline.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// When rsp_ready is low and the output register is full, the next result parks in a skid
// register and the whole pipeline freezes; req_ready drops only while the skid is full.
`timescale 1ns / 1ps

module circumcircle_three_points (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cc3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cc3_pkg::rsp_type rsp_data
);

   logic                 en;
   logic                 setup_vld, div_vld, center_vld, sqrt_vld;
   cc3_pkg::div_in_type  setup_data;
   cc3_pkg::div_out_type div_data;
   cc3_pkg::sq_in_type   center_data;
   cc3_pkg::sq_out_type  sqrt_data;

   logic             fin_vld_ff, fin_vld_in;
   cc3_pkg::rsp_type fin_ff, fin_in;
   logic             rsp_vld_ff, rsp_vld_in;
   cc3_pkg::rsp_type rsp_ff, rsp_in;
   logic             skid_vld_ff, skid_vld_in;
   cc3_pkg::rsp_type skid_ff, skid_in;
   logic             push, out_free;

   assign en        = ~skid_vld_ff;
   assign req_ready = en;

   cc3_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .out_vld  (setup_vld),
      .out_data (setup_data)
   );

   cc3_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (setup_vld),
      .in_data  (setup_data),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   cc3_center u_center (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (div_vld),
      .in_data  (div_data),
      .out_vld  (center_vld),
      .out_data (center_data)
   );

   cc3_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (center_vld),
      .in_data  (center_data),
      .out_vld  (sqrt_vld),
      .out_data (sqrt_data)
   );

   // final stage: halve the root with rounding, clamp, pick the status
   always_comb begin
      logic [cc3_pkg::RTW:0]   rp;
      cc3_pkg::root_type       hr;
      logic                    over;
      logic                    sat;
      cc3_pkg::sq_tag_type     t;
      t    = sqrt_data.tag;
      rp   = {1'b0, sqrt_data.root} + 1'b1;
      hr   = rp[cc3_pkg::RTW:1];
      over = t.big | (|hr[cc3_pkg::RTW-1:cc3_pkg::OUT_BITS]);
      sat  = over | t.satc;
      fin_vld_in = sqrt_vld;
      if (t.coll & ~t.dup) begin
         fin_in.center_x = '0;
         fin_in.center_y = '0;
         fin_in.radius   = '0;
         fin_in.status   = cc3_pkg::ST_COLL;
      end else begin
         fin_in.center_x = t.cx32;
         fin_in.center_y = t.cy32;
         fin_in.radius   = over ? cc3_pkg::UMAX : hr[cc3_pkg::OUT_BITS-1:0];
         fin_in.status   = sat ? cc3_pkg::ST_SAT : (t.dup ? cc3_pkg::ST_DUP : cc3_pkg::ST_CIRCLE);
      end
   end

   assign push     = en & fin_vld_ff;
   assign out_free = ~rsp_vld_ff | rsp_ready;

   // output register with one skid entry
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      priority if (skid_vld_ff) begin
         if (out_free) begin
            rsp_vld_in  = 1'b1;
            rsp_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (out_free) begin
            rsp_vld_in = 1'b1;
            rsp_in     = fin_ff;
         end else begin
            skid_vld_in = 1'b1;
            skid_in     = fin_ff;
         end
      end else begin
         if (out_free) begin
            rsp_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            fin_vld_ff <= fin_vld_in;
         end
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid entry held while output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff & ~rsp_ready))
      else $error("skid entry filled without an output stall");

   a_coll_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.status == cc3_pkg::ST_COLL) |->
         (rsp_ff.center_x == '0) && (rsp_ff.center_y == '0) && (rsp_ff.radius == '0))
      else $error("collinear result carries nonzero fields");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.status == cc3_pkg::ST_SAT) |->
         (rsp_ff.radius == cc3_pkg::UMAX) ||
         (rsp_ff.center_x == cc3_pkg::SMAX) || (rsp_ff.center_x == cc3_pkg::SMIN) ||
         (rsp_ff.center_y == cc3_pkg::SMAX) || (rsp_ff.center_y == cc3_pkg::SMIN))
      else $error("saturated status without a field at its limit");

endmodule
